// ----- design/rfa_pkg.sv -----
// Package for the rational fraction ALU: payload word types, operation codes and widths.
// Used by every module of the block; it depends on nothing else.
package rfa_pkg;

    localparam int unsigned DefOperandWidth = 16;
    localparam int unsigned FieldWidth      = 16;
    localparam int unsigned ResWidth        = 48;
    localparam int unsigned DenWidth        = 47;

    // Operation codes.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;
    localparam logic [1:0] OP_SUB = 2'd3;

    // One input word.
    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [FieldWidth-1:0] a_num;
        logic signed [FieldWidth-1:0] a_den;
        logic signed [FieldWidth-1:0] b_num;
        logic signed [FieldWidth-1:0] b_den;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic signed [ResWidth-1:0] raw_num;
        logic signed [ResWidth-1:0] raw_den;
        logic signed [ResWidth-1:0] red_num;
        logic [DenWidth-1:0]        red_den;
        logic                       error;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture input word, check denominators
        logic mul;       // one product step (step code selects operands)
        logic [2:0] mstep;
        logic gcd_init;  // start a GCD of the x and y registers
        logic gcd_step;  // one subtract/shift GCD step
        logic div_init;  // start a restoring division
        logic div_step;  // one quotient bit
        logic [2:0] sel; // which values to route into gcd/div units
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_err;   // input denominator zero
        logic raw_err;  // raw denominator zero
        logic num_zero; // raw numerator zero
        logic is_addsub;
        logic gcd_done;
        logic div_done;
    } t_status;

    // Routing codes for sel.
    localparam logic [2:0] SEL_GCD_DEN  = 3'd0; // gcd(|ad|,|bd|)
    localparam logic [2:0] SEL_LCM_Q    = 3'd1; // |ad| / g
    localparam logic [2:0] SEL_TA_Q     = 3'd2; // L / |ad|
    localparam logic [2:0] SEL_TB_Q     = 3'd3; // L / |bd|
    localparam logic [2:0] SEL_GCD_RES  = 3'd4; // gcd(|n|,|d|)
    localparam logic [2:0] SEL_RN_Q     = 3'd5; // |n| / g
    localparam logic [2:0] SEL_RD_Q     = 3'd6; // |d| / g

    // Multiply step codes.
    localparam logic [2:0] MS_RAW_N = 3'd0; // raw numerator product
    localparam logic [2:0] MS_RAW_D = 3'd1; // raw denominator product
    localparam logic [2:0] MS_LCM   = 3'd2; // L = (|ad|/g)*|bd|
    localparam logic [2:0] MS_TA    = 3'd3; // ta = q*ua
    localparam logic [2:0] MS_TB    = 3'd4; // tb = q*ub, then combine

endpackage

// ----- design/rational_fraction_alu.sv -----
// Rational fraction ALU: multiplies, divides, adds or subtracts two signed fractions and
// returns the raw result and the result reduced by the greatest common divisor, with a
// positive denominator. One word is worked at a time. A multiply or divide needs one GCD
// run and two divisions, and an add or subtract two GCD runs and five divisions, all on the
// binary GCD unit and the shared restoring divider, which makes one quotient bit a cycle over
// 64 bits. A zero input denominator skips all arithmetic, and a zero raw numerator or
// denominator skips the reduction. The output register lets the next word start while a
// result waits.
// Depends on rfa_pkg, rfa_ctrl and rfa_datapath.
module rational_fraction_alu
    import rfa_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = DefOperandWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);
    t_cmd      cmd;
    t_status   status;
    t_out_word result;
    logic      capture;
    t_out_word r_out;

    rfa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_status(status), .o_cmd(cmd), .o_capture(capture)
    );

    rfa_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_word(i_data),
        .i_cmd(cmd), .o_status(status), .o_result(result)
    );

    // Output register, loaded when a word finishes.
    always_ff @(posedge i_clk) begin
        if (capture) r_out <= result;
    end
    assign o_data = r_out;
endmodule

// ----- design/rfa_datapath.sv -----
// Datapath of the rational fraction ALU: operand registers, a shared multiplier,
// a binary GCD unit and a restoring divider. Depends on rfa_pkg.
module rfa_datapath
    import rfa_pkg::*;
#(
    parameter int unsigned OPERAND_WIDTH = DefOperandWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_word,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_word o_result
);
    localparam int unsigned W  = 64;
    localparam int unsigned MW = 33;
    localparam int unsigned RW = ResWidth;
    localparam int unsigned CW = $clog2(W + 1);

    logic [1:0]   r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;   // sign-extended operands
    logic [W-1:0] r_g, r_l, r_q, r_ta, r_rn, r_rd, r_qn;
    logic [W-1:0] r_gx, r_gy;
    logic [CW-1:0] r_gsh;
    logic [W-1:0] r_dn, r_dd, r_rem, r_quo;
    logic [CW-1:0] r_dcnt;
    logic         r_in_err;

    // Operand sign extension from the low OPERAND_WIDTH bits.
    function automatic logic [W-1:0] sx(input logic [FieldWidth-1:0] v);
        logic [W-1:0] t, m;
        m = (W'(1) << OPERAND_WIDTH) - W'(1);
        t = W'(v) & m;
        if (t[OPERAND_WIDTH-1]) t = t | ~m;
        return t;
    endfunction

    function automatic logic [W-1:0] mg(input logic [W-1:0] v);
        return v[W-1] ? (W'(0) - v) : v;
    endfunction

    // Sign-extend a 48-bit value held in the low bits.
    function automatic logic [W-1:0] s48(input logic [W-1:0] v);
        return {{(W-RW){v[RW-1]}}, v[RW-1:0]};
    endfunction

    logic [W-1:0] mag_ad, mag_bd, ua, ub, n48, d48;
    assign mag_ad = mg(r_ad);
    assign mag_bd = mg(r_bd);
    assign ua = r_ad[W-1] ? (W'(0) - r_an) : r_an;
    assign ub = r_bd[W-1] ? (W'(0) - r_bn) : r_bn;
    assign n48 = s48(r_rn);
    assign d48 = s48(r_rd);

    // Shared multiplier operands; products wrap modulo 2^64.
    logic [W-1:0] mul_a, mul_b, mul_p;
    logic signed [2*MW-1:0] mul_full;
    always_comb begin
        case (i_cmd.mstep)
            MS_RAW_N: begin mul_a = r_an; mul_b = (r_op == OP_DIV) ? r_bd : r_bn; end
            MS_RAW_D: begin mul_a = r_ad; mul_b = (r_op == OP_DIV) ? r_bn : r_bd; end
            MS_LCM:   begin mul_a = r_quo; mul_b = mag_bd; end
            MS_TA:    begin mul_a = r_quo; mul_b = ua; end
            MS_TB:    begin mul_a = r_quo; mul_b = ub; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end
    // Every multiplier operand fits in 33 signed bits, so the low 64 bits of the
    // 33 by 33 product equal the full product modulo 2^64.
    assign mul_full = $signed(mul_a[MW-1:0]) * $signed(mul_b[MW-1:0]);
    assign mul_p    = mul_full[W-1:0];

    // Routing of GCD and divider operands.
    logic [W-1:0] gx0, gy0, dn0, dd0;
    always_comb begin
        gx0 = mag_ad; gy0 = mag_bd; dn0 = mag_ad; dd0 = r_g;
        case (i_cmd.sel)
            SEL_GCD_DEN: begin gx0 = mag_ad; gy0 = mag_bd; end
            SEL_LCM_Q:   begin dn0 = mag_ad; dd0 = r_g; end
            SEL_TA_Q:    begin dn0 = r_l; dd0 = mag_ad; end
            SEL_TB_Q:    begin dn0 = r_l; dd0 = mag_bd; end
            SEL_GCD_RES: begin gx0 = mg(n48); gy0 = mg(d48); end
            SEL_RN_Q:    begin dn0 = mg(n48); dd0 = r_g; end
            SEL_RD_Q:    begin dn0 = mg(d48); dd0 = r_g; end
            default:     begin gx0 = mag_ad; gy0 = mag_bd; end
        endcase
    end

    // Binary GCD step: remove common twos, then subtract the smaller odd value.
    logic [W-1:0] n_gx, n_gy;
    logic [CW-1:0] n_gsh;
    always_comb begin
        n_gx = r_gx; n_gy = r_gy; n_gsh = r_gsh;
        if (r_gy != '0 && r_gx != '0) begin
            if (!r_gx[0] && !r_gy[0]) begin
                n_gx = r_gx >> 1; n_gy = r_gy >> 1; n_gsh = r_gsh + CW'(1);
            end else if (!r_gx[0]) begin
                n_gx = r_gx >> 1;
            end else if (!r_gy[0]) begin
                n_gy = r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                n_gx = (r_gx - r_gy) >> 1;
            end else begin
                n_gy = (r_gy - r_gx) >> 1;
            end
        end
    end
    logic gcd_done;
    assign gcd_done = (r_gx == '0) || (r_gy == '0);

    // Restoring division step, one quotient bit per cycle.
    logic [W:0] rem_sh, rem_sub;
    assign rem_sh  = {r_rem, r_dn[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_word.req_type;
            r_an <= sx(i_word.a_num);
            r_ad <= sx(i_word.a_den);
            r_bn <= sx(i_word.b_num);
            r_bd <= sx(i_word.b_den);
        end
        if (i_cmd.mul) begin
            case (i_cmd.mstep)
                MS_RAW_N: r_rn <= mul_p;
                MS_RAW_D: r_rd <= mul_p;
                MS_LCM:   begin r_l <= mul_p; r_rd <= mul_p; end
                MS_TA:    r_ta <= mul_p;
                MS_TB:    r_rn <= (r_op == OP_ADD) ? r_ta + mul_p : r_ta - mul_p;
                default:  r_rn <= r_rn;
            endcase
        end
        if (i_cmd.gcd_init) begin
            r_gx <= gx0; r_gy <= gy0; r_gsh <= '0;
        end else if (i_cmd.gcd_step) begin
            r_gx <= n_gx; r_gy <= n_gy; r_gsh <= n_gsh;
            if (gcd_done) r_g <= (r_gx | r_gy) << r_gsh;
        end
        if (i_cmd.div_init) begin
            r_dn <= dn0; r_dd <= dd0; r_rem <= '0; r_quo <= '0; r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dn <= r_dn << 1;
            r_dcnt <= r_dcnt + CW'(1);
            if (!rem_sub[W]) begin
                r_rem <= rem_sub[W-1:0]; r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];  r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
        if (i_cmd.sel == SEL_RD_Q && i_cmd.div_init) r_qn <= r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_err <= 1'b0;
        else if (i_cmd.load)
            r_in_err <= (sx(i_word.a_den) == '0) || (sx(i_word.b_den) == '0);
    end

    assign o_status.in_err    = r_in_err;
    assign o_status.raw_err   = (d48 == '0);
    assign o_status.num_zero  = (n48 == '0);
    assign o_status.is_addsub = r_op[1];
    assign o_status.gcd_done  = gcd_done;
    assign o_status.div_done  = (r_dcnt == CW'(W));

    // Result word; reduced fields valid once the last division ends.
    logic neg;
    logic [W-1:0] red_n;
    assign neg   = n48[W-1] ^ d48[W-1];
    assign red_n = neg ? (W'(0) - r_qn) : r_qn;
    always_comb begin
        o_result = '0;
        o_result.error = 1'b1;
        if (!r_in_err && d48 != '0) begin
            o_result.error   = 1'b0;
            o_result.raw_num = r_rn[RW-1:0];
            o_result.raw_den = r_rd[RW-1:0];
            if (n48 == '0) begin
                o_result.red_num = '0;
                o_result.red_den = DenWidth'(1);
            end else begin
                o_result.red_num = red_n[RW-1:0];
                o_result.red_den = r_quo[DenWidth-1:0];
            end
        end
    end
endmodule

// ----- design/rfa_ctrl.sv -----
// Controller of the rational fraction ALU: sequences multiply, GCD and divide steps
// and owns the input and output handshakes. Depends on rfa_pkg.
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_capture
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RAWN  = 13'b0000000000010,
        S_RAWD  = 13'b0000000000100,
        S_GD    = 13'b0000000001000,
        S_DIV   = 13'b0000000010000,
        S_MUL   = 13'b0000000100000,
        S_CHK   = 13'b0000001000000,
        S_GR    = 13'b0000010000000,
        S_DONE  = 13'b0000100000000,
        S_RN    = 13'b0001000000000,
        S_RD    = 13'b0010000000000,
        S_GI    = 13'b0100000000000,
        S_DI    = 13'b1000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_sel, n_sel;    // current routing / phase
    logic       r_ovalid, n_ovalid;

    // Next state and command decode.
    always_comb begin
        n_state = r_state; n_sel = r_sel; n_ovalid = r_ovalid;
        o_cmd = '0; o_cmd.sel = r_sel; o_capture = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1; n_state = S_RAWN;
            end
            S_RAWN: begin
                if (i_status.in_err) n_state = S_DONE;
                else if (i_status.is_addsub) begin
                    n_sel = SEL_GCD_DEN; n_state = S_GI;
                end else begin
                    o_cmd.mul = 1'b1; o_cmd.mstep = MS_RAW_N; n_state = S_RAWD;
                end
            end
            S_RAWD: begin
                o_cmd.mul = 1'b1; o_cmd.mstep = MS_RAW_D; n_state = S_CHK;
            end
            S_GI: begin
                o_cmd.gcd_init = 1'b1; n_state = S_GD;
            end
            S_GD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_status.gcd_done)
                    n_state = (r_sel == SEL_GCD_DEN) ? S_DI : S_RN;
                if (i_status.gcd_done) n_sel = (r_sel == SEL_GCD_DEN) ? SEL_LCM_Q : SEL_RN_Q;
            end
            S_DI: begin
                o_cmd.div_init = 1'b1; n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step = 1'b0;
                    case (r_sel)
                        SEL_LCM_Q, SEL_TA_Q, SEL_TB_Q: n_state = S_MUL;
                        SEL_RN_Q: begin n_sel = SEL_RD_Q; n_state = S_RD; end
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                case (r_sel)
                    SEL_LCM_Q: begin o_cmd.mstep = MS_LCM; n_sel = SEL_TA_Q; n_state = S_DI; end
                    SEL_TA_Q:  begin o_cmd.mstep = MS_TA;  n_sel = SEL_TB_Q; n_state = S_DI; end
                    default:   begin o_cmd.mstep = MS_TB;  n_state = S_CHK; end
                endcase
            end
            S_CHK: begin
                if (i_status.raw_err || i_status.num_zero) n_state = S_DONE;
                else begin n_sel = SEL_GCD_RES; n_state = S_GR; end
            end
            S_GR: begin
                o_cmd.gcd_init = 1'b1; n_state = S_GD;
            end
            S_RN: begin
                o_cmd.div_init = 1'b1; n_state = S_DIV;
            end
            S_RD: begin
                // Latch |n|/g, then divide |d| by g.
                o_cmd.div_init = 1'b1; n_state = S_DIV;
            end
            S_DONE: if (!n_ovalid) begin
                n_ovalid = 1'b1; o_capture = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sel <= SEL_GCD_DEN; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_sel <= n_sel; r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
endmodule

// ----- design/rfa_checker.sv -----
// Port checker for the rational fraction ALU, bound to the top level.
// Depends on rfa_pkg.
module rfa_checker
    import rfa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_data
);
    // A held result keeps its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // An error result carries zero fields.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error |-> o_data.red_den == '0 && o_data.raw_den == '0)
        else $error("error result has nonzero fields");

    // A good result has a nonzero reduced denominator.
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.error |-> o_data.red_den != '0)
        else $error("zero reduced denominator");

    // A word accepted cannot be answered in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result too early");
endmodule

bind rational_fraction_alu rfa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);

// ----- tb/sv/rational_fraction_alu_tb.sv -----
// Self-checking testbench for the rational fraction ALU: a built-in predictor of the
// fraction arithmetic checks every result word. Depends on rfa_pkg and rational_fraction_alu.
module rational_fraction_alu_tb
    import rfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OpWidth    = 16;
    localparam int unsigned IdleLimit  = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_word o_data;

    t_out_word expected_words[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    bit        calm_mode = 1'b0;
    bit        hold_request = 1'b0;

    rational_fraction_alu #(.OPERAND_WIDTH(OpWidth)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #2 i_clk = ~i_clk;

    // Sign-extend the low operand bits of a field.
    function automatic longint operand(logic [15:0] f);
        logic [63:0] v;
        v = {{48{f[OpWidth-1]}}, f};
        return longint'(v);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Predict the result word for one input word.
    function automatic t_out_word fraction_result(t_in_word w);
        t_out_word r;
        longint an, ad, bn, bd, n, d;
        longint unsigned rn, rd, c, e, g, l, ua, ub, qn, qd;
        an = operand(w.a_num); ad = operand(w.a_den);
        bn = operand(w.b_num); bd = operand(w.b_den);
        r = '0;
        r.error = 1'b1;
        if (ad == 0 || bd == 0) return r;
        case (w.req_type)
            OP_MUL: begin
                rn = 64'(an) * 64'(bn);
                rd = 64'(ad) * 64'(bd);
            end
            OP_DIV: begin
                rn = 64'(an) * 64'(bd);
                rd = 64'(ad) * 64'(bn);
            end
            default: begin
                c = magnitude(ad); e = magnitude(bd);
                ua = (ad < 0) ? 64'(-an) : 64'(an);
                ub = (bd < 0) ? 64'(-bn) : 64'(bn);
                g = gcd_of(c, e);
                l = (c / g) * e;
                rn = (w.req_type == OP_ADD) ? (l / c) * ua + (l / e) * ub
                                            : (l / c) * ua - (l / e) * ub;
                rd = l;
            end
        endcase
        n = longint'({{16{rn[47]}}, rn[47:0]});
        d = longint'({{16{rd[47]}}, rd[47:0]});
        if (d == 0) return r;
        r.error = 1'b0;
        r.raw_num = rn[47:0];
        r.raw_den = rd[47:0];
        if (n == 0) begin
            r.red_den = 47'd1;
        end else begin
            g = gcd_of(magnitude(n), magnitude(d));
            qn = magnitude(n) / g;
            qd = magnitude(d) / g;
            r.red_num = 48'(((n < 0) != (d < 0)) ? -qn : qn);
            r.red_den = qd[46:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Send one word, with a random gap before it unless idling is off.
    task automatic send_word(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
                             logic [15:0] bn, logic [15:0] bd);
        t_in_word w;
        w = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        if (!calm_mode) begin
            while ($urandom_range(99) < 16) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= w;
        expected_words.push_back(fraction_result(w));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(8)) - 4);
            3: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver stall: random idling, none in calm mode, or a long hold when asked.
    always @(posedge i_clk) begin
        if (hold_request) i_stall <= 1'b1;
        else if (calm_mode) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 16);
    end

    // Check each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_data.raw_num !== want.raw_num)
                    report_mismatch("raw_num", o_data.raw_num, want.raw_num);
                if (o_data.raw_den !== want.raw_den)
                    report_mismatch("raw_den", o_data.raw_den, want.raw_den);
                if (o_data.red_num !== want.red_num)
                    report_mismatch("red_num", o_data.red_num, want.red_num);
                if (o_data.red_den !== want.red_den)
                    report_mismatch("red_den", o_data.red_den, want.red_den);
                if (o_data.error !== want.error)
                    report_mismatch("error", o_data.error, want.error);
            end
        end
    end

    // Watchdog on cycles with no word accepted on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        logic [1:0] op;
        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            send_word(op, 16'd3, 16'd4, 16'd5, 16'd6);
            send_word(op, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
            send_word(op, 16'd0, 16'hFFFD, 16'd7, 16'd2);
            send_word(op, 16'd1, 16'd0, 16'd2, 16'd3);
            send_word(op, 16'hFFFF, 16'hFFFE, 16'd0, 16'hFFFF);
        end
        send_word(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd9);
        send_word(OP_SUB, 16'd2, 16'd4, 16'd1, 16'd2);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_word(2'($urandom), rand_field(), rand_field(), rand_field(), rand_field());
    endtask

    task automatic test_no_idle(int count);
        calm_mode = 1'b1;
        test_random(count);
        calm_mode = 1'b0;
    endtask

    // Hold the output long enough that the block fills and stalls its input.
    task automatic test_backpressure();
        hold_request = 1'b1;
        fork
            test_random(6);
            begin
                repeat (2000) @(posedge i_clk);
                hold_request = 1'b0;
            end
        join
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        test_no_idle(250);
        test_backpressure();
        test_random(470);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/rfa_pkg.sv
design/rfa_datapath.sv
design/rfa_ctrl.sv
design/rational_fraction_alu.sv
design/rfa_checker.sv
tb/sv/rational_fraction_alu_tb.sv
